// ===== sv/servo_command_frame_parser_core_macros.svh =====
// Assertion helpers for the parser RTL.
`ifndef SERVO_COMMAND_FRAME_PARSER_CORE_MACROS_SVH
`define SERVO_COMMAND_FRAME_PARSER_CORE_MACROS_SVH

// Clocked check, quiet while reset is held.
`define SCFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define SCFP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/scfp_pkg.sv =====
package scfp_pkg;

    // Group size limit and the counter width that follows from it.
    localparam int MAX_GROUP_FRAMES = 6;
    localparam int GCNT_W           = $clog2(MAX_GROUP_FRAMES + 1);

    // Field widths.
    localparam int ID_ACC_W = 10;
    localparam int ACC_W    = 14;
    localparam int LEN_W    = 3;

    // Configuration register reset values.
    localparam logic [7:0]       MAX_ID_RST    = 8'd5;
    localparam logic [ACC_W-1:0] PULSE_MIN_RST = 14'd500;
    localparam logic [ACC_W-1:0] PULSE_MAX_RST = 14'd2500;

    // Configuration register indexes.
    localparam logic [1:0] REG_ID_MAX    = 2'd0;
    localparam logic [1:0] REG_PULSE_MIN = 2'd1;
    localparam logic [1:0] REG_PULSE_MAX = 2'd2;

    // Field length limits.
    localparam logic [LEN_W-1:0] ID_LEN_MAX  = 3'd3;
    localparam logic [LEN_W-1:0] NUM_LEN_MAX = 3'd4;
    localparam logic [LEN_W-1:0] LEN_SAT     = 3'd7;

    // Characters of the command syntax.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // Result kinds.
    localparam logic [1:0] KIND_SINGLE    = 2'd0;
    localparam logic [1:0] KIND_GROUP     = 2'd1;
    localparam logic [1:0] KIND_GROUP_END = 2'd2;
    localparam logic [1:0] KIND_REJECT    = 2'd3;

    // Range status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ID_RANGE = 2'd1;
    localparam logic [1:0] ST_PW_RANGE = 2'd2;

    // Parse phases, one-hot.
    typedef enum logic [12:0] {
        PH_IDLE        = 13'b0000000000001,
        PH_SKIP        = 13'b0000000000010,
        PH_DEAD        = 13'b0000000000100,
        PH_S_ID        = 13'b0000000001000,
        PH_S_PULSE     = 13'b0000000010000,
        PH_S_PULSE_BAD = 13'b0000000100000,
        PH_S_TIME      = 13'b0000001000000,
        PH_S_TIME_BAD  = 13'b0000010000000,
        PH_G_SEEK      = 13'b0000100000000,
        PH_G_ID        = 13'b0001000000000,
        PH_G_PULSE     = 13'b0010000000000,
        PH_G_TIME      = 13'b0100000000000,
        PH_G_FULL      = 13'b1000000000000
    } scfp_phase_t;

    // One received byte.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_message;
    } scfp_byte_t;

    // Range limits.
    typedef struct packed {
        logic [7:0]       id_max;
        logic [ACC_W-1:0] pulse_min;
        logic [ACC_W-1:0] pulse_max;
    } scfp_cfg_t;

    // One result.
    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       status;
        logic [7:0]       unit_id;
        logic [ACC_W-1:0] pulse_width;
        logic [ACC_W-1:0] move_time;
    } scfp_result_t;

    // Accumulator step outcome.
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [LEN_W-1:0] len;
        logic             done;
    } scfp_feed_t;

    function automatic logic scfp_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic scfp_len_ok(input logic [LEN_W-1:0] len,
                                         input logic [LEN_W-1:0] lim);
        return (len != '0) && (len <= lim);
    endfunction

    // One character into a decimal field: digits count until the first
    // non-digit or the length limit, the length saturates at seven.
    function automatic scfp_feed_t scfp_feed(input logic [ACC_W-1:0] acc,
                                             input logic [7:0]       c,
                                             input logic [LEN_W-1:0] len,
                                             input logic             done,
                                             input logic [LEN_W-1:0] lim);
        scfp_feed_t  r;
        logic [17:0] times10;
        r.acc   = acc;
        r.done  = done;
        times10 = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                + {10'd0, c - CH_ZERO};
        if ((len < lim) && !done) begin
            if (scfp_is_digit(c)) begin
                r.acc = times10[ACC_W-1:0];
            end else begin
                r.done = 1'b1;
            end
        end
        r.len = (len < LEN_SAT) ? len + 3'd1 : len;
        return r;
    endfunction

endpackage

// ===== sv/scfp_in_reg.sv =====
module scfp_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] char_byte
    input  logic                s_tlast,    // end_of_message
    output logic                item_valid,
    output scfp_pkg::scfp_byte_t item,
    input  logic                take
);
    import scfp_pkg::*;

    logic       valid_reg;
    scfp_byte_t byte_reg;

    // Room when empty or when the held byte leaves this cycle.
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = byte_reg;

    // Occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    // Byte capture.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg.char_byte      <= s_tdata;
            byte_reg.end_of_message <= s_tlast;
        end
    end

endmodule

// ===== sv/scfp_parse.sv =====
module scfp_parse (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  scfp_pkg::scfp_cfg_t   cfg,
    input  logic                  item_valid,
    input  scfp_pkg::scfp_byte_t  item,
    output logic                  take,
    input  logic                  out_free,
    output logic                  push,
    output scfp_pkg::scfp_result_t result
);
    import scfp_pkg::*;

    scfp_phase_t           phase_reg, phase_next;
    logic [ID_ACC_W-1:0]   id_reg, id_next;
    logic [ACC_W-1:0]      pulse_reg, pulse_next;
    logic [ACC_W-1:0]      time_reg, time_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  done_reg, done_next;
    logic [GCNT_W-1:0]     gcnt_reg, gcnt_next;

    logic                  emit;
    logic                  grp;
    logic [7:0]            c;
    logic [1:0]            status;
    logic [GCNT_W-1:0]     gcnt_inc;
    scfp_feed_t            fd_id, fd_pulse, fd_time;

    assign c        = item.char_byte;
    assign grp      = (phase_reg == PH_G_SEEK) || (phase_reg == PH_G_ID) ||
                      (phase_reg == PH_G_PULSE) || (phase_reg == PH_G_TIME) ||
                      (phase_reg == PH_G_FULL);
    assign gcnt_inc = gcnt_reg + GCNT_W'(1);

    // Field accumulator steps.
    assign fd_id    = scfp_feed({{(ACC_W-ID_ACC_W){1'b0}}, id_reg}, c, len_reg,
                                done_reg, ID_LEN_MAX);
    assign fd_pulse = scfp_feed(pulse_reg, c, len_reg, done_reg, NUM_LEN_MAX);
    assign fd_time  = scfp_feed(time_reg, c, len_reg, done_reg, NUM_LEN_MAX);

    // Range status, id checked first.
    always_comb begin
        if (id_reg[7:0] > cfg.id_max) begin
            status = ST_ID_RANGE;
        end else if ((pulse_reg < cfg.pulse_min) || (pulse_reg > cfg.pulse_max)) begin
            status = ST_PW_RANGE;
        end else begin
            status = ST_OK;
        end
    end

    // Next state and result for the byte at the head of the input register.
    always_comb begin
        phase_next = phase_reg;
        id_next    = id_reg;
        pulse_next = pulse_reg;
        time_next  = time_reg;
        len_next   = len_reg;
        done_next  = done_reg;
        gcnt_next  = gcnt_reg;
        emit       = 1'b0;
        result     = '0;

        if (phase_reg == PH_DEAD) begin
            // wait for the end of the message
        end else if (c == CH_NUL) begin
            phase_next = PH_DEAD;
        end else if (c == CH_SEMI) begin
            phase_next = PH_IDLE;
        end else if (grp && (c == CH_RBRACE)) begin
            emit        = 1'b1;
            result.kind = KIND_GROUP_END;
            phase_next  = PH_SKIP;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if ((c == CH_SPACE) || (c == CH_CR) || (c == CH_LF)) begin
                        phase_next = PH_IDLE;
                    end else if (c == CH_HASH) begin
                        id_next    = '0;
                        pulse_next = '0;
                        time_next  = '0;
                        len_next   = '0;
                        done_next  = 1'b0;
                        phase_next = PH_S_ID;
                    end else if (c == CH_LBRACE) begin
                        gcnt_next  = '0;
                        phase_next = PH_G_SEEK;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_S_ID: begin
                    if ((len_reg == '0) && !scfp_is_digit(c)) begin
                        phase_next = PH_SKIP;
                    end else if (c == CH_P) begin
                        phase_next = scfp_len_ok(len_reg, ID_LEN_MAX) ?
                                     PH_S_PULSE : PH_S_PULSE_BAD;
                        len_next   = '0;
                        done_next  = 1'b0;
                    end else begin
                        id_next   = fd_id.acc[ID_ACC_W-1:0];
                        len_next  = fd_id.len;
                        done_next = fd_id.done;
                    end
                end
                PH_S_PULSE: begin
                    if (c == CH_T) begin
                        phase_next = scfp_len_ok(len_reg, NUM_LEN_MAX) ?
                                     PH_S_TIME : PH_S_TIME_BAD;
                        len_next   = '0;
                        done_next  = 1'b0;
                    end else begin
                        pulse_next = fd_pulse.acc;
                        len_next   = fd_pulse.len;
                        done_next  = fd_pulse.done;
                    end
                end
                PH_S_PULSE_BAD: begin
                    if (c == CH_T) begin
                        phase_next = PH_S_TIME_BAD;
                    end
                end
                PH_S_TIME: begin
                    if (c == CH_BANG) begin
                        emit = 1'b1;
                        if (scfp_len_ok(len_reg, NUM_LEN_MAX)) begin
                            result.kind        = KIND_SINGLE;
                            result.status      = status;
                            result.unit_id     = id_reg[7:0];
                            result.pulse_width = pulse_reg;
                            result.move_time   = time_reg;
                        end else begin
                            result.kind = KIND_REJECT;
                        end
                        phase_next = PH_SKIP;
                    end else begin
                        time_next = fd_time.acc;
                        len_next  = fd_time.len;
                        done_next = fd_time.done;
                    end
                end
                PH_S_TIME_BAD: begin
                    if (c == CH_BANG) begin
                        emit        = 1'b1;
                        result.kind = KIND_REJECT;
                        phase_next  = PH_SKIP;
                    end
                end
                PH_G_SEEK: begin
                    if (c == CH_HASH) begin
                        id_next    = '0;
                        pulse_next = '0;
                        time_next  = '0;
                        len_next   = '0;
                        done_next  = 1'b0;
                        phase_next = PH_G_ID;
                    end
                end
                PH_G_ID: begin
                    if (c == CH_P) begin
                        len_next   = '0;
                        done_next  = 1'b0;
                        phase_next = PH_G_PULSE;
                    end else begin
                        id_next   = fd_id.acc[ID_ACC_W-1:0];
                        len_next  = fd_id.len;
                        done_next = fd_id.done;
                    end
                end
                PH_G_PULSE: begin
                    if (c == CH_T) begin
                        len_next   = '0;
                        done_next  = 1'b0;
                        phase_next = PH_G_TIME;
                    end else begin
                        pulse_next = fd_pulse.acc;
                        len_next   = fd_pulse.len;
                        done_next  = fd_pulse.done;
                    end
                end
                PH_G_TIME: begin
                    if (c == CH_BANG) begin
                        emit               = 1'b1;
                        result.kind        = KIND_GROUP;
                        result.status      = status;
                        result.unit_id     = id_reg[7:0];
                        result.pulse_width = pulse_reg;
                        result.move_time   = time_reg;
                        gcnt_next          = gcnt_inc;
                        phase_next = (gcnt_inc >= GCNT_W'(MAX_GROUP_FRAMES)) ?
                                     PH_G_FULL : PH_G_SEEK;
                    end else begin
                        time_next = fd_time.acc;
                        len_next  = fd_time.len;
                        done_next = fd_time.done;
                    end
                end
                default: begin
                    // skip, group full: nothing until a restart
                end
            endcase
        end

        // End of message restarts parsing.
        if (item.end_of_message) begin
            phase_next = PH_IDLE;
        end
    end

    // A byte with a result waits for space in the output register.
    assign take = item_valid && (!emit || out_free);
    assign push = take && emit;

    // Parse state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            id_reg    <= '0;
            pulse_reg <= '0;
            time_reg  <= '0;
            len_reg   <= '0;
            done_reg  <= 1'b0;
            gcnt_reg  <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            pulse_reg <= pulse_next;
            time_reg  <= time_next;
            len_reg   <= len_next;
            done_reg  <= done_next;
            gcnt_reg  <= gcnt_next;
        end
    end

endmodule

// ===== sv/scfp_out_reg.sv =====
module scfp_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  scfp_pkg::scfp_result_t result,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,  // [1:0] status, [9:2] unit_id,
                                            // [23:10] pulse_width,
                                            // [37:24] move_time, [39:38] zero
    output logic [1:0]            m_tuser   // [1:0] kind
);
    import scfp_pkg::*;

    logic         valid_reg;
    scfp_result_t res_reg;

    // Free when empty or when the held result is taken this cycle.
    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {2'b00, res_reg.move_time, res_reg.pulse_width,
                       res_reg.unit_id, res_reg.status};

    // Occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Result capture.
    always_ff @(posedge aclk) begin
        if (push) begin
            res_reg <= result;
        end
    end

endmodule

// ===== sv/servo_command_frame_parser_core.sv =====
// Servo command frame parser: takes one ASCII byte per transfer on the s_
// stream (s_tlast marks the last byte of a message) and delivers one result
// per completed '#id P pulse T time !' frame, per group end '}' and per
// rejected single frame on the m_ stream; m_tuser carries the kind. A byte
// is registered on entry, parse logic updates the small phase and accumulator
// registers as the byte is taken and a result is registered on exit; bytes
// are taken at one per cycle while the output register has room, the rate
// set by the single parse-state update made for each byte. Limits are
// written on the cfg_ port (index 0 max servo id, 1 pulse min, 2 pulse max)
// by the user while the stream is idle, unenforced; cfg_ready is always high.
`include "servo_command_frame_parser_core_macros.svh"

module servo_command_frame_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_byte
    input  logic        s_tlast,    // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [1:0] status, [9:2] unit_id,
                                    // [23:10] pulse_width, [37:24] move_time,
                                    // [39:38] zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);
    import scfp_pkg::*;

    scfp_cfg_t    cfg_reg;
    scfp_byte_t   item;
    scfp_result_t result;
    logic         item_valid;
    logic         take;
    logic         push;
    logic         out_free;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.id_max    <= MAX_ID_RST;
            cfg_reg.pulse_min <= PULSE_MIN_RST;
            cfg_reg.pulse_max <= PULSE_MAX_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ID_MAX:    cfg_reg.id_max    <= cfg_data[7:0];
                REG_PULSE_MIN: cfg_reg.pulse_min <= cfg_data;
                REG_PULSE_MAX: cfg_reg.pulse_max <= cfg_data;
                default: begin
                    // unused index
                end
            endcase
        end
    end

    scfp_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    scfp_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_free   (out_free),
        .push       (push),
        .result     (result)
    );

    scfp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Checks.
    `SCFP_ASSERT(a_marker_no_fields, m_tvalid && ((m_tuser == KIND_GROUP_END) || (m_tuser == KIND_REJECT)) |-> (m_tdata == '0), "group end or reject carries field data")
    `SCFP_ASSERT(a_status_code, m_tvalid |-> (m_tdata[1:0] != 2'd3), "undefined status code")
    `SCFP_ASSERT(a_byte_held, item_valid && !take |=> item_valid, "held byte dropped while stalled")
    `SCFP_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid && !item_valid, "pipeline not empty after reset")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import scfp_pkg::*;

    localparam int STALL_LIMIT  = 2000;   // cycles with no transfer anywhere
    localparam int DRAIN_CYCLES = 8;      // idle clocks after the last expected result
    localparam int BLOCK_BYTES  = 334;    // six random blocks, about 2000 bytes
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7a;

    // DUT ports
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [7:0] char_byte
    logic        s_tlast   = 1'b0;  // end_of_message
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;           // [1:0] status, [9:2] unit_id,
                                    // [23:10] pulse_width, [37:24] move_time
    logic [1:0]  m_tuser;           // [1:0] kind
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [13:0] cfg_data  = '0;

    servo_command_frame_parser_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Parser state as predicted from the accepted bytes
    scfp_phase_t  ph;
    logic [9:0]   acc_id;
    logic [13:0]  acc_pw;
    logic [13:0]  acc_mt;
    logic [2:0]   fld_len;
    logic         fld_stop;
    logic [2:0]   grp_frames;
    logic [7:0]   lim_id;
    logic [13:0]  lim_pw_lo;
    logic [13:0]  lim_pw_hi;
    scfp_result_t pending_frames[$];

    // Traffic shaping and bookkeeping
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    int unsigned  bytes_sent;
    int unsigned  mismatch_count;
    int unsigned  stall_cycles;
    logic [7:0]   msg_bytes[$];

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic field_fits(input logic [2:0] lim);
        return (fld_len != 3'd0) && (fld_len <= lim);
    endfunction

    function automatic void open_field();
        fld_len  = 3'd0;
        fld_stop = 1'b0;
    endfunction

    // atoi-style accumulation, capped at lim digits; length saturates at 7
    function automatic logic [13:0] shift_in_digit(input logic [13:0] acc,
                                                   input logic [7:0]  c,
                                                   input logic [2:0]  lim);
        logic [13:0] r;
        r = acc;
        if ((fld_len < lim) && !fld_stop) begin
            if (is_numeral(c)) begin
                r = acc * 14'd10 + {6'd0, c - CH_ZERO};
            end else begin
                fld_stop = 1'b1;
            end
        end
        if (fld_len < LEN_SAT) begin
            fld_len = fld_len + 3'd1;
        end
        return r;
    endfunction

    function automatic scfp_result_t frame_result(input logic [1:0] kind);
        scfp_result_t r;
        r.kind        = kind;
        r.unit_id     = acc_id[7:0];
        r.pulse_width = acc_pw;
        r.move_time   = acc_mt;
        if (acc_id[7:0] > lim_id) begin
            r.status = ST_ID_RANGE;
        end else if ((acc_pw < lim_pw_lo) || (acc_pw > lim_pw_hi)) begin
            r.status = ST_PW_RANGE;
        end else begin
            r.status = ST_OK;
        end
        return r;
    endfunction

    function automatic scfp_result_t marker_result(input logic [1:0] kind);
        scfp_result_t r;
        r      = '0;
        r.kind = kind;
        return r;
    endfunction

    // Advance the predicted parser by one accepted byte
    function automatic void parse_byte(input logic [7:0] c, input logic eom);
        logic in_grp;
        in_grp = (ph == PH_G_SEEK) || (ph == PH_G_ID) || (ph == PH_G_PULSE) ||
                 (ph == PH_G_TIME) || (ph == PH_G_FULL);
        if (ph == PH_DEAD) begin
            // everything up to end of message is dropped
        end else if (c == CH_NUL) begin
            ph = PH_DEAD;
        end else if (c == CH_SEMI) begin
            ph = PH_IDLE;
        end else if (in_grp && (c == CH_RBRACE)) begin
            pending_frames.push_back(marker_result(KIND_GROUP_END));
            ph = PH_SKIP;
        end else begin
            case (ph)
                PH_IDLE: begin
                    if ((c == CH_SPACE) || (c == CH_CR) || (c == CH_LF)) begin
                        // leading blank
                    end else if (c == CH_HASH) begin
                        acc_id = '0; acc_pw = '0; acc_mt = '0;
                        open_field();
                        ph = PH_S_ID;
                    end else if (c == CH_LBRACE) begin
                        grp_frames = '0;
                        ph = PH_G_SEEK;
                    end else begin
                        ph = PH_SKIP;
                    end
                end
                PH_S_ID: begin
                    if ((fld_len == 3'd0) && !is_numeral(c)) begin
                        ph = PH_SKIP;
                    end else if (c == CH_P) begin
                        ph = field_fits(ID_LEN_MAX) ? PH_S_PULSE : PH_S_PULSE_BAD;
                        open_field();
                    end else begin
                        acc_id = 10'(shift_in_digit({4'd0, acc_id}, c, ID_LEN_MAX));
                    end
                end
                PH_S_PULSE: begin
                    if (c == CH_T) begin
                        ph = field_fits(NUM_LEN_MAX) ? PH_S_TIME : PH_S_TIME_BAD;
                        open_field();
                    end else begin
                        acc_pw = shift_in_digit(acc_pw, c, NUM_LEN_MAX);
                    end
                end
                PH_S_PULSE_BAD: begin
                    if (c == CH_T) begin
                        ph = PH_S_TIME_BAD;
                    end
                end
                PH_S_TIME: begin
                    if (c == CH_BANG) begin
                        if (field_fits(NUM_LEN_MAX)) begin
                            pending_frames.push_back(frame_result(KIND_SINGLE));
                        end else begin
                            pending_frames.push_back(marker_result(KIND_REJECT));
                        end
                        ph = PH_SKIP;
                    end else begin
                        acc_mt = shift_in_digit(acc_mt, c, NUM_LEN_MAX);
                    end
                end
                PH_S_TIME_BAD: begin
                    if (c == CH_BANG) begin
                        pending_frames.push_back(marker_result(KIND_REJECT));
                        ph = PH_SKIP;
                    end
                end
                PH_G_SEEK: begin
                    if (c == CH_HASH) begin
                        acc_id = '0; acc_pw = '0; acc_mt = '0;
                        open_field();
                        ph = PH_G_ID;
                    end
                end
                PH_G_ID: begin
                    if (c == CH_P) begin
                        open_field();
                        ph = PH_G_PULSE;
                    end else begin
                        acc_id = 10'(shift_in_digit({4'd0, acc_id}, c, ID_LEN_MAX));
                    end
                end
                PH_G_PULSE: begin
                    if (c == CH_T) begin
                        open_field();
                        ph = PH_G_TIME;
                    end else begin
                        acc_pw = shift_in_digit(acc_pw, c, NUM_LEN_MAX);
                    end
                end
                PH_G_TIME: begin
                    if (c == CH_BANG) begin
                        pending_frames.push_back(frame_result(KIND_GROUP));
                        grp_frames = grp_frames + 3'd1;
                        ph = (grp_frames >= MAX_GROUP_FRAMES) ? PH_G_FULL : PH_G_SEEK;
                    end else begin
                        acc_mt = shift_in_digit(acc_mt, c, NUM_LEN_MAX);
                    end
                end
                default: begin
                end
            endcase
        end
        if (eom) begin
            ph = PH_IDLE;
        end
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Message building
    function automatic void push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            msg_bytes.push_back(s[i]);
        end
    endfunction

    function automatic void push_blank();
        case ($urandom_range(2))
            0: msg_bytes.push_back(CH_SPACE);
            1: msg_bytes.push_back(CH_CR);
            default: msg_bytes.push_back(CH_LF);
        endcase
    endfunction

    // filler that neither opens a frame nor closes a group
    function automatic void push_filler(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(1) == 0) begin
                msg_bytes.push_back(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
            end else begin
                msg_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
        end
    endfunction

    // decimal field: mostly legal length, sometimes empty or overlong
    function automatic void push_field(input int unsigned max_len);
        int unsigned len;
        int unsigned pick;
        int unsigned i;
        pick = $urandom_range(99);
        if (pick < 5) begin
            len = 0;
        end else if (pick < 82) begin
            len = $urandom_range(1, max_len);
        end else begin
            len = $urandom_range(max_len + 1, max_len + 3);
        end
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 90) begin
                msg_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
            end else if (pick < 98) begin
                msg_bytes.push_back(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
            end else begin
                msg_bytes.push_back(8'($urandom_range(255)));
            end
        end
    endfunction

    function automatic void push_frame();
        msg_bytes.push_back(CH_HASH);
        push_field(ID_LEN_MAX);
        msg_bytes.push_back(CH_P);
        push_field(NUM_LEN_MAX);
        msg_bytes.push_back(CH_T);
        push_field(NUM_LEN_MAX);
        msg_bytes.push_back(CH_BANG);
    endfunction

    function automatic void push_segment();
        int unsigned pick;
        int unsigned start;
        int unsigned cut;
        pick  = $urandom_range(99);
        start = msg_bytes.size();
        if (pick < 40) begin
            // single frame, maybe blanks before and ignored bytes after
            repeat ($urandom_range(2)) push_blank();
            push_frame();
            if ($urandom_range(3) == 0) push_filler($urandom_range(1, 3));
        end else if (pick < 72) begin
            // group, possibly over-full or left unclosed
            msg_bytes.push_back(CH_LBRACE);
            repeat ($urandom_range(8)) begin
                if ($urandom_range(3) == 0) push_filler($urandom_range(1, 3));
                push_frame();
            end
            if ($urandom_range(9) != 0) msg_bytes.push_back(CH_RBRACE);
            if ($urandom_range(4) == 0) push_frame();
        end else if (pick < 84) begin
            // frame cut short
            if ($urandom_range(1) == 0) msg_bytes.push_back(CH_LBRACE);
            push_frame();
            cut = $urandom_range(1, msg_bytes.size() - start - 1);
            repeat (cut) void'(msg_bytes.pop_back());
        end else if (pick < 92) begin
            repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom_range(255)));
        end else if (pick < 96) begin
            // '#' not followed by a digit
            msg_bytes.push_back(CH_HASH);
            if ($urandom_range(1) == 0) begin
                msg_bytes.push_back(CH_P);
            end else begin
                push_blank();
            end
            push_frame();
        end else begin
            // NUL hides everything up to end of message, ';' included
            msg_bytes.push_back(CH_NUL);
            msg_bytes.push_back(CH_SEMI);
            push_frame();
        end
    endfunction

    // Stimulus driving
    task automatic send_byte(input logic [7:0] c, input logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eom;
        // ready has settled by the falling edge; the transfer is at the next rising edge
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        parse_byte(c, eom);
    endtask

    // sends msg_bytes as one message, end flag on the last byte
    task automatic send_message();
        int i;
        for (i = 0; i < msg_bytes.size(); i++) begin
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        end
        bytes_sent += msg_bytes.size();
        msg_bytes.delete();
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_message();
    endtask

    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        case (idx)
            REG_ID_MAX:    lim_id    = val[7:0];
            REG_PULSE_MIN: lim_pw_lo = val;
            REG_PULSE_MAX: lim_pw_hi = val;
            default: begin
            end
        endcase
    endtask

    task automatic set_limits(input logic [7:0] id_max, input logic [13:0] lo,
                              input logic [13:0] hi);
        write_reg(REG_ID_MAX, {6'd0, id_max});
        write_reg(REG_PULSE_MIN, lo);
        write_reg(REG_PULSE_MAX, hi);
        cfg_valid <= 1'b0;
    endtask

    // Random messages under one limit setting
    task automatic run_block(input int idx);
        int unsigned lo;
        int unsigned stop_at;
        drain_stream();
        case (idx)
            0: set_limits(8'd255, 14'd0, 14'd9999);
            1: set_limits(8'd0, 14'd9999, 14'd0);
            5: set_limits(MAX_ID_RST, PULSE_MIN_RST, PULSE_MAX_RST);
            default: begin
                lo = $urandom_range(3000);
                set_limits(8'($urandom_range(255)), 14'(lo),
                           14'($urandom_range(lo, 9999)));
            end
        endcase
        stop_at = bytes_sent + BLOCK_BYTES;
        while (bytes_sent < stop_at) begin
            repeat ($urandom_range(1, 3)) begin
                if (msg_bytes.size() != 0) msg_bytes.push_back(CH_SEMI);
                push_segment();
            end
            send_message();
        end
    endtask

    // Tests
    task automatic test_single_frames();
        send_text("#255P9999T0!");   // widest id and pulse fields, id over the default limit
        send_text("#1234P1T1!");     // four-digit id rejects the frame
    endtask

    task automatic test_group_frames();
        send_text("{#0P0T9999!}");   // smallest id and pulse inside a group, then its end
    endtask

    task automatic test_random_stream(input int unsigned s_pct, input int unsigned r_pct,
                                      input int first_block);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        run_block(first_block);
        run_block(first_block + 1);
    endtask

    // Result checking and receiver stalls
    always @(posedge aclk) begin : result_check
        scfp_result_t want;
        scfp_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind        = m_tuser;
            got.status      = m_tdata[1:0];
            got.unit_id     = m_tdata[9:2];
            got.pulse_width = m_tdata[23:10];
            got.move_time   = m_tdata[37:24];
            if (pending_frames.size() == 0) begin
                flag_mismatch($sformatf("unexpected result kind %0d id %0d pw %0d mt %0d",
                              got.kind, got.unit_id, got.pulse_width, got.move_time));
            end else begin
                want = pending_frames.pop_front();
                if (got.kind != want.kind)
                    flag_mismatch($sformatf("kind exp %0d got %0d", want.kind, got.kind));
                if (got.status != want.status)
                    flag_mismatch($sformatf("status exp %0d got %0d",
                                  want.status, got.status));
                if (got.unit_id != want.unit_id)
                    flag_mismatch($sformatf("unit_id exp %0d got %0d",
                                  want.unit_id, got.unit_id));
                if (got.pulse_width != want.pulse_width)
                    flag_mismatch($sformatf("pulse_width exp %0d got %0d",
                                  want.pulse_width, got.pulse_width));
                if (got.move_time != want.move_time)
                    flag_mismatch($sformatf("move_time exp %0d got %0d",
                                  want.move_time, got.move_time));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: no transfer on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("servo_command_frame_parser_core regression: fail");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

    initial begin
        ph             = PH_IDLE;
        acc_id         = '0;
        acc_pw         = '0;
        acc_mt         = '0;
        fld_len        = '0;
        fld_stop       = 1'b0;
        grp_frames     = '0;
        lim_id         = MAX_ID_RST;
        lim_pw_lo      = PULSE_MIN_RST;
        lim_pw_hi      = PULSE_MAX_RST;
        send_idle_pct  = 38;
        recv_idle_pct  = 75;
        bytes_sent     = 0;
        mismatch_count = 0;
        stall_cycles   = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_frames();
        test_group_frames();
        test_random_stream(38, 75, 0);
        test_random_stream(75, 38, 2);
        test_random_stream(0, 0, 4);
        drain_stream();

        if (mismatch_count == 0) begin
            $display("servo_command_frame_parser_core regression: pass");
        end else begin
            $display("servo_command_frame_parser_core regression: fail");
        end
        $finish;
    end

endmodule
